// File: rtl/alpha_from_black_white_pair_unit_defines.svh
// Assertion macros for the verification files of the block.
`ifndef ALPHA_FROM_BLACK_WHITE_PAIR_UNIT_DEFINES_SVH
`define ALPHA_FROM_BLACK_WHITE_PAIR_UNIT_DEFINES_SVH

// Checked at every edge once reset is released.
`define AFBW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("afbw assertion failed");

// Checked at every edge, reset included.
`define AFBW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("afbw assertion failed during or after reset");

`endif

// File: rtl/afbw_pkg.sv
package afbw_pkg;

  localparam int unsigned CHAN_MAX   = 255;
  localparam int unsigned CHAN_N     = 3;
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_TOL   = 2'd0,
    REG_TRANSPARENT = 2'd1
  } afbw_reg_t;

  typedef struct packed {
    logic [7:0] dark_blue;
    logic [7:0] dark_green;
    logic [7:0] dark_red;
    logic [7:0] light_blue;
    logic [7:0] light_green;
    logic [7:0] light_red;
    logic       last_in;
  } afbw_in_t;

  typedef struct packed {
    logic [7:0] res_blue;
    logic [7:0] res_green;
    logic [7:0] res_red;
    logic [7:0] res_alpha;
    logic       last_out;
  } afbw_out_t;

  typedef struct packed {
    logic       sat;
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quot;
  } afbw_lane_t;

  typedef struct packed {
    logic                    last;
    logic                    visible;
    logic [7:0]              alpha;
    afbw_lane_t [CHAN_N-1:0] lane;
  } afbw_div_t;

endpackage

// File: rtl/afbw_alpha.sv
module afbw_alpha
  import afbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] tol,
  input  logic       in_valid,
  output logic       in_stall,
  input  afbw_in_t   in_data,
  output logic       dn_valid,
  input  logic       dn_stall,
  output afbw_div_t  dn_data
);

  logic             a_valid_r;
  logic [SUM_W-1:0] a_sum_r;
  logic [7:0]       a_dark_r [CHAN_N];
  logic             a_last_r;

  logic             b_valid_r;
  logic [7:0]       b_alpha_r;
  logic [7:0]       b_dark_r [CHAN_N];
  logic             b_last_r;

  logic             c_valid_r;
  afbw_div_t        c_data_r;

  logic             a_adv, b_adv, c_adv;
  logic [9:0]       dark_sum, light_sum;
  logic [SUM_W-1:0] a_sum_nxt;
  logic [SUM_W+9:0] prod;
  logic [9:0]       quot3;
  logic [7:0]       b_alpha_nxt;
  afbw_div_t        c_data_nxt;

  assign c_adv    = !c_valid_r || !dn_stall;
  assign b_adv    = !b_valid_r || c_adv;
  assign a_adv    = !a_valid_r || b_adv;
  assign in_stall = !a_adv;
  assign dn_valid = c_valid_r;
  assign dn_data  = c_data_r;

  always_comb begin
    dark_sum  = 10'(in_data.dark_blue) + 10'(in_data.dark_green) + 10'(in_data.dark_red);
    light_sum = 10'(in_data.light_blue) + 10'(in_data.light_green) + 10'(in_data.light_red);
    a_sum_nxt = SUM_W'(CHAN_N * CHAN_MAX) + SUM_W'(dark_sum) - SUM_W'(light_sum);
  end

  always_comb begin
    prod        = (SUM_W + 10)'(a_sum_r) * (SUM_W + 10)'(DIV3_MUL);
    quot3       = prod[DIV3_SHIFT +: 10];
    b_alpha_nxt = (quot3 > 10'(CHAN_MAX)) ? 8'(CHAN_MAX) : quot3[7:0];
  end

  always_comb begin
    logic [15:0] num;
    c_data_nxt         = '0;
    c_data_nxt.last    = b_last_r;
    c_data_nxt.alpha   = b_alpha_r;
    c_data_nxt.visible = b_alpha_r > tol;
    for (int c = 0; c < CHAN_N; c++) begin
      num                      = {b_dark_r[c], 8'h00} - {8'h00, b_dark_r[c]};
      c_data_nxt.lane[c].sat   = b_dark_r[c] >= b_alpha_r;
      c_data_nxt.lane[c].rem   = num[15:8];
      c_data_nxt.lane[c].low   = num[7:0];
      c_data_nxt.lane[c].quot  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= in_valid;
      end
      if (b_adv) begin
        b_valid_r <= a_valid_r;
      end
      if (c_adv) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_sum_r     <= a_sum_nxt;
      a_dark_r[0] <= in_data.dark_blue;
      a_dark_r[1] <= in_data.dark_green;
      a_dark_r[2] <= in_data.dark_red;
      a_last_r    <= in_data.last_in;
    end
    if (b_adv && a_valid_r) begin
      b_alpha_r <= b_alpha_nxt;
      b_dark_r  <= a_dark_r;
      b_last_r  <= a_last_r;
    end
    if (c_adv && b_valid_r) begin
      c_data_r <= c_data_nxt;
    end
  end

endmodule

// File: rtl/afbw_div_stage.sv
module afbw_div_stage
  import afbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_stall,
  input  afbw_div_t up_data,
  output logic      dn_valid,
  input  logic      dn_stall,
  output afbw_div_t dn_data
);

  logic      valid_r;
  afbw_div_t data_r;
  afbw_div_t data_nxt;
  logic      adv;

  assign adv      = !valid_r || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Restoring division, one quotient bit per step for each color lane.
  always_comb begin
    logic [8:0] trial;
    logic       qbit;
    data_nxt = up_data;
    for (int c = 0; c < CHAN_N; c++) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {data_nxt.lane[c].rem, data_nxt.lane[c].low[7]};
        if (trial >= {1'b0, data_nxt.alpha}) begin
          data_nxt.lane[c].rem = 8'(trial - {1'b0, data_nxt.alpha});
          qbit                 = 1'b1;
        end else begin
          data_nxt.lane[c].rem = trial[7:0];
          qbit                 = 1'b0;
        end
        data_nxt.lane[c].low  = {data_nxt.lane[c].low[6:0], 1'b0};
        data_nxt.lane[c].quot = {data_nxt.lane[c].quot[6:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/alpha_from_black_white_pair_unit.sv
// Throughput: one pixel per cycle; three alpha stages, four two-bit divider stages
// and the output register each hold one pixel, and a stall only freezes full stages.
// Reset (rst_n low at a rising edge) empties the pipeline and clears
// alpha_tolerance and transparent_word to zero.
module alpha_from_black_white_pair_unit
  import afbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  afbw_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output afbw_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]            tol_r;
  logic [CFG_DATA_W-1:0] transparent_r;

  logic      div_valid [0:DIV_STAGES];
  logic      div_stall [0:DIV_STAGES];
  afbw_div_t div_data  [0:DIV_STAGES];

  logic      out_valid_r;
  afbw_out_t out_data_r;
  afbw_out_t out_data_nxt;
  logic      out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r         <= '0;
      transparent_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_TOL:   tol_r         <= cfg_wdata[7:0];
        REG_TRANSPARENT: transparent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  afbw_alpha u_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .tol      (tol_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .dn_valid (div_valid[0]),
    .dn_stall (div_stall[0]),
    .dn_data  (div_data[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    afbw_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_valid[g]),
      .up_stall (div_stall[g]),
      .up_data  (div_data[g]),
      .dn_valid (div_valid[g+1]),
      .dn_stall (div_stall[g+1]),
      .dn_data  (div_data[g+1])
    );
  end

  assign out_adv               = !out_valid_r || !out_stall;
  assign div_stall[DIV_STAGES] = !out_adv;
  assign out_valid             = out_valid_r;
  assign out_data              = out_data_r;

  always_comb begin
    afbw_div_t d;
    d                     = div_data[DIV_STAGES];
    out_data_nxt.last_out = d.last;
    if (d.visible) begin
      out_data_nxt.res_blue  = d.lane[0].sat ? 8'(CHAN_MAX) : d.lane[0].quot;
      out_data_nxt.res_green = d.lane[1].sat ? 8'(CHAN_MAX) : d.lane[1].quot;
      out_data_nxt.res_red   = d.lane[2].sat ? 8'(CHAN_MAX) : d.lane[2].quot;
      out_data_nxt.res_alpha = d.alpha;
    end else begin
      out_data_nxt.res_blue  = transparent_r[7:0];
      out_data_nxt.res_green = transparent_r[15:8];
      out_data_nxt.res_red   = transparent_r[23:16];
      out_data_nxt.res_alpha = transparent_r[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && div_valid[DIV_STAGES]) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/afbw_checker.sv
`include "alpha_from_black_white_pair_unit_defines.svh"

module afbw_checker
  import afbw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input afbw_out_t             out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]            tol_r;
  logic [CFG_DATA_W-1:0] tw_r;
  logic                  shows_tw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      tw_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_TOL:   tol_r <= cfg_wdata[7:0];
        REG_TRANSPARENT: tw_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign shows_tw = (out_data.res_blue == tw_r[7:0]) &&
                    (out_data.res_green == tw_r[15:8]) &&
                    (out_data.res_red == tw_r[23:16]) &&
                    (out_data.res_alpha == tw_r[31:24]);

  // A result whose alpha is at or below the tolerance can only be the transparent color.
  `AFBW_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid)
  `AFBW_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(out_data))
  `AFBW_ASSERT(a_flows_when_free, !out_stall |-> !in_stall)
  `AFBW_ASSERT(a_transparent, out_valid && (out_data.res_alpha <= tol_r) |-> shows_tw)

endmodule

bind alpha_from_black_white_pair_unit afbw_checker u_afbw_checker (.*);

// File: dv/alpha_from_black_white_pair_unit_tb.sv
module alpha_from_black_white_pair_unit_tb;
  import afbw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int HOLD_CYCLES   = 80;
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_PIXELS  = 230;
  localparam int FLOOD_PIXELS  = 40;

  class afbw_scoreboard;
    logic [7:0]  tolerance;
    logic [31:0] transparent;
    afbw_out_t   expected_q[$];
    int          errors;

    function new();
      tolerance   = '0;
      transparent = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ALPHA_TOL:   tolerance = val[7:0];
        REG_TRANSPARENT: transparent = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] unpremultiply(logic [7:0] dark, int unsigned opacity);
      int unsigned v;
      v = dark * CHAN_MAX / opacity;
      return (v > CHAN_MAX) ? 8'(CHAN_MAX) : v[7:0];
    endfunction

    function void note_pixel(afbw_in_t p);
      int unsigned total;
      int unsigned opacity;
      afbw_out_t   r;
      total = CHAN_N * CHAN_MAX + p.dark_blue + p.dark_green + p.dark_red
              - p.light_blue - p.light_green - p.light_red;
      opacity = total / CHAN_N;
      if (opacity > CHAN_MAX) opacity = CHAN_MAX;
      if (opacity > tolerance) begin
        r.res_blue  = unpremultiply(p.dark_blue, opacity);
        r.res_green = unpremultiply(p.dark_green, opacity);
        r.res_red   = unpremultiply(p.dark_red, opacity);
        r.res_alpha = opacity[7:0];
      end else begin
        r.res_blue  = transparent[7:0];
        r.res_green = transparent[15:8];
        r.res_red   = transparent[23:16];
        r.res_alpha = transparent[31:24];
      end
      r.last_out = p.last_in;
      expected_q = {expected_q, r};
    endfunction

    function void check_pixel(afbw_out_t got);
      afbw_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.res_blue !== want.res_blue) begin
        $error("res_blue: expected %0d, actual %0d", want.res_blue, got.res_blue);
        errors++;
      end
      if (got.res_green !== want.res_green) begin
        $error("res_green: expected %0d, actual %0d", want.res_green, got.res_green);
        errors++;
      end
      if (got.res_red !== want.res_red) begin
        $error("res_red: expected %0d, actual %0d", want.res_red, got.res_red);
        errors++;
      end
      if (got.res_alpha !== want.res_alpha) begin
        $error("res_alpha: expected %0d, actual %0d", want.res_alpha, got.res_alpha);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  afbw_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  afbw_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit             calm        = 1'b0;
  bit             hold_req    = 1'b0;
  int             idle_cycles = 0;
  int unsigned    cur_tol     = 0;
  afbw_scoreboard pixel_board;

  always #2 clk = ~clk;

  alpha_from_black_white_pair_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) pixel_board.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) pixel_board.note_pixel(in_data);
      if (out_valid && !out_stall) pixel_board.check_pixel(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("alpha_from_black_white_pair_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (calm || $urandom_range(0, 99) < 60) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end else begin
        out_stall <= 1'b1;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(afbw_in_t pix);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic afbw_in_t pixel_of(int unsigned db, int unsigned dg, int unsigned dr,
                                        int unsigned lb, int unsigned lg, int unsigned lr,
                                        bit last);
    afbw_in_t p;
    p.dark_blue   = db[7:0];
    p.dark_green  = dg[7:0];
    p.dark_red    = dr[7:0];
    p.light_blue  = lb[7:0];
    p.light_green = lg[7:0];
    p.light_red   = lr[7:0];
    p.last_in     = last;
    return p;
  endfunction

  // Half the pixels are consistent black/white renderings, many of them with alpha
  // within one of the tolerance; the rest are raw noise or saturated bytes.
  function automatic afbw_in_t random_pixel(int unsigned threshold);
    afbw_in_t    p;
    logic [63:0] noise;
    int unsigned kind;
    int unsigned opacity;
    int unsigned dark [3];
    int          t;
    noise = {$urandom, $urandom};
    p = noise[$bits(afbw_in_t)-1:0];
    kind = $urandom_range(0, 9);
    if (kind >= 4 && kind <= 8) begin
      if ($urandom_range(0, 1)) begin
        opacity = $urandom_range(0, 255);
      end else begin
        t = threshold;
        t += $urandom_range(0, 2);
        t -= 1;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        opacity = t;
      end
      foreach (dark[i]) dark[i] = $urandom_range(0, 255) * opacity / CHAN_MAX;
      p = pixel_of(dark[0], dark[1], dark[2], dark[0] + CHAN_MAX - opacity,
                   dark[1] + CHAN_MAX - opacity, dark[2] + CHAN_MAX - opacity,
                   p.last_in);
    end else if (kind == 9) begin
      if ($urandom_range(0, 2) == 0) p.dark_blue = '0;
      else if ($urandom_range(0, 1) == 0) p.dark_blue = '1;
      if ($urandom_range(0, 2) == 0) p.dark_green = '0;
      else if ($urandom_range(0, 1) == 0) p.dark_green = '1;
      if ($urandom_range(0, 2) == 0) p.dark_red = '0;
      else if ($urandom_range(0, 1) == 0) p.dark_red = '1;
      if ($urandom_range(0, 2) == 0) p.light_blue = '0;
      else if ($urandom_range(0, 1) == 0) p.light_blue = '1;
      if ($urandom_range(0, 2) == 0) p.light_green = '0;
      else if ($urandom_range(0, 1) == 0) p.light_green = '1;
      if ($urandom_range(0, 2) == 0) p.light_red = '0;
      else if ($urandom_range(0, 1) == 0) p.light_red = '1;
    end
    return p;
  endfunction

  initial begin : stimulus
    int unsigned tol_plan [6];
    pixel_board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(pixel_of(0, 0, 0, 255, 255, 255, 0));
    send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 1));
    send_pixel(pixel_of(255, 255, 255, 0, 0, 0, 0));
    send_pixel(pixel_of(255, 255, 255, 255, 255, 255, 1));
    send_pixel(pixel_of(200, 0, 0, 255, 255, 255, 0));
    send_pixel(pixel_of(3, 0, 0, 255, 255, 255, 0));
    send_pixel(pixel_of(2, 0, 0, 255, 255, 255, 1));
    send_pixel(pixel_of(128, 64, 32, 160, 224, 255, 0));
    send_pixel(pixel_of(1, 0, 0, 0, 0, 0, 0));
    send_pixel(pixel_of(0, 0, 0, 1, 1, 0, 0));
    settle();

    write_cfg(REG_ALPHA_TOL, 32'h0000_00FF);
    write_cfg(REG_TRANSPARENT, 32'hFFFF_FFFF);
    write_cfg(REG_SPARE_LO, 32'h0000_0000);
    write_cfg(REG_SPARE_HI, 32'h0000_0000);
    send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 1));
    send_pixel(pixel_of(255, 0, 255, 0, 255, 0, 0));
    settle();

    write_cfg(REG_ALPHA_TOL, 32'h0000_0080);
    write_cfg(REG_TRANSPARENT, 32'hA5C3_5A3C);
    send_pixel(pixel_of(128, 128, 128, 255, 255, 255, 0));
    send_pixel(pixel_of(129, 129, 129, 255, 255, 255, 1));
    send_pixel(pixel_of(64, 0, 0, 190, 126, 126, 0));
    settle();

    tol_plan[0] = 0;
    tol_plan[1] = 255;
    tol_plan[2] = 1;
    tol_plan[3] = 254;
    tol_plan[4] = $urandom_range(0, 255);
    tol_plan[5] = $urandom_range(0, 255);
    foreach (tol_plan[ph]) begin
      cur_tol = tol_plan[ph];
      write_cfg(REG_ALPHA_TOL, cur_tol);
      write_cfg(REG_TRANSPARENT, $urandom);
      if ($urandom_range(0, 1)) write_cfg(REG_SPARE_LO, $urandom);
      else write_cfg(REG_SPARE_HI, $urandom);
      repeat (PHASE_PIXELS) send_pixel(random_pixel(cur_tol));
      if (ph == 2) begin
        // Output held off while pixels keep coming, so the pipeline backs up.
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (FLOOD_PIXELS) send_pixel(random_pixel(cur_tol));
        calm = 1'b0;
      end
      settle();
    end

    if (pixel_board.errors == 0 && pixel_board.pending() == 0) begin
      $display("alpha_from_black_white_pair_unit verification clean");
    end else begin
      $display("alpha_from_black_white_pair_unit verification failed");
    end
    $finish;
  end

endmodule
